// ===== hw/rtl/fpci_pkg.sv =====
// ---------------------------------------------------------------------------
// fpci_pkg
// Shared types, constants and saturating helpers for the four-point cubic
// interpolator pipeline.
// ---------------------------------------------------------------------------
package fpci_pkg;

  // Working word: signed Q31.16, kept within +-(2^47-1)
  typedef logic signed [47:0] word_t;
  // Magnitude of a working word
  typedef logic [46:0] mag_t;

  localparam word_t WMAX  = 48'sh7FFF_FFFF_FFFF;
  localparam word_t ONE_Q = 48'sh0000_0001_0000;

  // Output clamp bounds (signed 32-bit range)
  localparam word_t OUT_MAX = 48'sh0000_7FFF_FFFF;
  localparam word_t OUT_MIN = 48'shFFFF_8000_0000;

  // Sum bounds, one bit wider than a working word
  localparam logic signed [48:0] SUM_MAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] SUM_MIN = -49'sh0_7FFF_FFFF_FFFF;

  // Total number of register stages from input to output
  localparam int PIPE_LEN = 137;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_RANGE   = 2'd1;
  localparam status_t STATUS_SPACING = 2'd2;

  typedef struct packed {
    logic signed [31:0] sample_before;
    logic signed [31:0] sample_near;
    logic signed [31:0] sample_far;
    logic signed [31:0] sample_after;
    logic signed [31:0] pos_before;
    logic signed [31:0] pos_near;
    logic signed [31:0] pos_far;
    logic signed [31:0] pos_after;
    logic signed [31:0] query_pos;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] interpolated;
    logic [1:0]         status;
  } out_item_t;

  // Magnitude of a word (never sees -2^47)
  function automatic mag_t mag_of(word_t v);
    word_t n;
    n = -v;
    return v[47] ? n[46:0] : v[46:0];
  endfunction

  // Clamp a 49-bit sum into the working range
  function automatic word_t clamp_sum(logic signed [48:0] s);
    word_t r;
    if (s > SUM_MAX) begin
      r = WMAX;
    end else if (s < SUM_MIN) begin
      r = -WMAX;
    end else begin
      r = s[47:0];
    end
    return r;
  endfunction

  function automatic word_t sat_add(word_t a, word_t b);
    logic signed [48:0] s;
    s = 49'(a) + 49'(b);
    return clamp_sum(s);
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic signed [48:0] s;
    s = 49'(a) - 49'(b);
    return clamp_sum(s);
  endfunction

endpackage

// ===== hw/rtl/four_point_cubic_interpolator.sv =====
// ---------------------------------------------------------------------------
// four_point_cubic_interpolator
// Four-point nonuniform cubic Hermite interpolation in signed Q16.16.
// ---------------------------------------------------------------------------
// Usage: a fully pipelined unit that takes one item per clock while the
// output is not held, and returns its results in order. The depth is set by
// two chained 50-stage restoring dividers (end slope parameter, then the end
// slope itself), each resolving one quotient bit per iteration stage, plus
// 5-stage multipliers for the end-slope terms and the polynomial. The whole
// pipeline advances together: while a result waits at the output, the
// pipeline holds and in_ready is low. status 1 flags a query outside the
// inner span, status 2 a zero divisor in any slope or offset division whose
// result is used; interpolated is zero whenever status is nonzero.
// ---------------------------------------------------------------------------
module four_point_cubic_interpolator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fpci_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fpci_pkg::out_item_t  out_data
);

  typedef struct packed {
    logic            outside;
    logic            eq_a;
    logic            eq_b;
    fpci_pkg::word_t g;
    fpci_pkg::word_t p;
    fpci_pkg::word_t dff;
    fpci_pkg::word_t fn;
    fpci_pkg::word_t fnff;
    fpci_pkg::word_t dfa;
    fpci_pkg::word_t dfb;
    fpci_pkg::word_t hc;
    fpci_pkg::word_t dpa;
  } side1_t;

  typedef struct packed {
    logic            outside;
    logic            eq_a;
    logic            eq_b;
    logic            z_k1;
    logic            z_k2;
    logic            z_pg;
    logic            z_eq;
    fpci_pkg::word_t g;
    fpci_pkg::word_t p;
    fpci_pkg::word_t dff;
    fpci_pkg::word_t fn;
    fpci_pkg::word_t eq_q;
    fpci_pkg::word_t pg;
  } side2_t;

  typedef struct packed {
    fpci_pkg::status_t status;
    fpci_pkg::word_t   g;
    fpci_pkg::word_t   p;
    fpci_pkg::word_t   dff;
    fpci_pkg::word_t   fn;
    fpci_pkg::word_t   pg;
    fpci_pkg::word_t   sf;
    fpci_pkg::word_t   sn;
  } side4_t;

  logic en;
  logic vld_r [fpci_pkg::PIPE_LEN];

  // global advance: everything moves unless the output is held
  assign en        = !vld_r[fpci_pkg::PIPE_LEN-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[fpci_pkg::PIPE_LEN-1];

  // valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fpci_pkg::PIPE_LEN; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < fpci_pkg::PIPE_LEN; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // ---------------- stage 0/1: input register, differences ----------------
  fpci_pkg::in_item_t in_r;
  side1_t             s1_nxt, s1_r;
  side1_t             a1_r [50];

  always_comb begin
    s1_nxt.g    = fpci_pkg::word_t'(in_r.pos_far) - fpci_pkg::word_t'(in_r.pos_near);
    s1_nxt.p    = fpci_pkg::word_t'(in_r.query_pos) - fpci_pkg::word_t'(in_r.pos_near);
    s1_nxt.dff  = fpci_pkg::word_t'(in_r.sample_far) - fpci_pkg::word_t'(in_r.sample_near);
    s1_nxt.fn   = fpci_pkg::word_t'(in_r.sample_near);
    s1_nxt.fnff = fpci_pkg::word_t'(in_r.sample_near) - fpci_pkg::word_t'(in_r.sample_far);
    s1_nxt.dfa  = fpci_pkg::word_t'(in_r.sample_after) - fpci_pkg::word_t'(in_r.sample_far);
    s1_nxt.dfb  = fpci_pkg::word_t'(in_r.sample_before) - fpci_pkg::word_t'(in_r.sample_near);
    s1_nxt.hc   = fpci_pkg::word_t'(in_r.pos_before) - fpci_pkg::word_t'(in_r.pos_near);
    s1_nxt.dpa  = fpci_pkg::word_t'(in_r.pos_after) - fpci_pkg::word_t'(in_r.pos_far);
    s1_nxt.eq_a = (in_r.sample_after == in_r.sample_far);
    s1_nxt.eq_b = (in_r.sample_before == in_r.sample_near);
    s1_nxt.outside = s1_nxt.p[47] || (s1_nxt.p > s1_nxt.g);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r  <= in_data;
      s1_r  <= s1_nxt;
      a1_r[0] <= s1_r;
      for (int j = 1; j < 50; j++) begin
        a1_r[j] <= a1_r[j-1];
      end
    end
  end

  // ---------------- first divides: slope parameters, offset ----------------
  fpci_pkg::word_t k1_q, k2_q, pg_q, eq_q;
  logic            k1_z, k2_z, pg_z, eq_z;

  fpci_div u_div_k1 (.clk(clk), .en(en), .num(s1_r.g),   .den(s1_r.dpa),
                     .quo(k1_q), .div_zero(k1_z));
  fpci_div u_div_k2 (.clk(clk), .en(en), .num(s1_r.hc),  .den(s1_r.g),
                     .quo(k2_q), .div_zero(k2_z));
  fpci_div u_div_pg (.clk(clk), .en(en), .num(s1_r.p),   .den(s1_r.g),
                     .quo(pg_q), .div_zero(pg_z));
  fpci_div u_div_eq (.clk(clk), .en(en), .num(s1_r.dff), .den(s1_r.g),
                     .quo(eq_q), .div_zero(eq_z));

  // ---------------- end-slope branches (0: far end, 1: near end) ----------
  side1_t          s51;
  fpci_pkg::word_t br_a [2];
  fpci_pkg::word_t br_k [2];
  fpci_pkg::word_t br_c [2];
  fpci_pkg::word_t br_d [2];
  fpci_pkg::word_t br_ka [2];
  fpci_pkg::word_t br_q [2];
  logic            br_z [2];

  assign s51 = a1_r[49];

  always_comb begin
    br_a[0]  = s51.dfa;
    br_k[0]  = k1_q;
    br_c[0]  = s51.fnff;
    br_d[0]  = -s51.g;
    br_ka[0] = k1_q;
    br_a[1]  = s51.dff;
    br_k[1]  = k2_q;
    br_c[1]  = s51.dfb;
    br_d[1]  = s51.hc;
    br_ka[1] = -k2_q;
  end

  for (genvar b = 0; b < 2; b++) begin : g_branch
    fpci_pkg::word_t k_dl_r   [5];
    fpci_pkg::word_t c_dl_r   [10];
    fpci_pkg::word_t den_dl_r [5];
    fpci_pkg::word_t d_r, sk_r, num_r;
    fpci_pkg::word_t m1, m2, den;

    // a*k, then (a*k)*k
    fpci_mul u_m1  (.clk(clk), .en(en), .a(br_a[b]), .b(br_k[b]), .prod(m1));
    fpci_mul u_m2  (.clk(clk), .en(en), .a(m1), .b(k_dl_r[4]), .prod(m2));
    // divisor: d * (1 +- k)
    fpci_mul u_den (.clk(clk), .en(en), .a(d_r), .b(sk_r), .prod(den));

    always_ff @(posedge clk) begin
      if (en) begin
        k_dl_r[0] <= br_k[b];
        for (int j = 1; j < 5; j++) begin
          k_dl_r[j] <= k_dl_r[j-1];
        end
        c_dl_r[0] <= br_c[b];
        for (int j = 1; j < 10; j++) begin
          c_dl_r[j] <= c_dl_r[j-1];
        end
        d_r  <= br_d[b];
        sk_r <= fpci_pkg::sat_add(fpci_pkg::ONE_Q, br_ka[b]);
        den_dl_r[0] <= den;
        for (int j = 1; j < 5; j++) begin
          den_dl_r[j] <= den_dl_r[j-1];
        end
        num_r <= fpci_pkg::sat_sub(c_dl_r[9], m2);
      end
    end

    fpci_div u_div (.clk(clk), .en(en), .num(num_r), .den(den_dl_r[4]),
                    .quo(br_q[b]), .div_zero(br_z[b]));
  end

  // ---------------- side data across the branch divides ----------------
  side2_t s2_nxt;
  side2_t a2_r [61];

  always_comb begin
    s2_nxt.outside = s51.outside;
    s2_nxt.eq_a    = s51.eq_a;
    s2_nxt.eq_b    = s51.eq_b;
    s2_nxt.z_k1    = k1_z;
    s2_nxt.z_k2    = k2_z;
    s2_nxt.z_pg    = pg_z;
    s2_nxt.z_eq    = eq_z;
    s2_nxt.g       = s51.g;
    s2_nxt.p       = s51.p;
    s2_nxt.dff     = s51.dff;
    s2_nxt.fn      = s51.fn;
    s2_nxt.eq_q    = eq_q;
    s2_nxt.pg      = pg_q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r[0] <= s2_nxt;
      for (int j = 1; j < 61; j++) begin
        a2_r[j] <= a2_r[j-1];
      end
    end
  end

  // ---------------- slope select and status ----------------
  side2_t s112;
  side4_t s4_nxt, s4_r;
  side4_t a4_r [7];
  logic   zero_any;

  assign s112 = a2_r[60];

  always_comb begin
    zero_any = s112.z_pg
             | (s112.eq_a ? s112.z_eq : (s112.z_k1 | br_z[0]))
             | (s112.eq_b ? s112.z_eq : (s112.z_k2 | br_z[1]));
    if (s112.outside) begin
      s4_nxt.status = fpci_pkg::STATUS_RANGE;
    end else if (zero_any) begin
      s4_nxt.status = fpci_pkg::STATUS_SPACING;
    end else begin
      s4_nxt.status = fpci_pkg::STATUS_OK;
    end
    s4_nxt.g   = s112.g;
    s4_nxt.p   = s112.p;
    s4_nxt.dff = s112.dff;
    s4_nxt.fn  = s112.fn;
    s4_nxt.pg  = s112.pg;
    s4_nxt.sf  = s112.eq_a ? s112.eq_q : br_q[0];
    s4_nxt.sn  = s112.eq_b ? s112.eq_q : br_q[1];
  end

  // ---------------- Hermite coefficients ----------------
  fpci_pkg::word_t gf, gn, sp, m_t2;
  fpci_pkg::word_t t2_r, r1_r, e1_r, e2_r, cc_r, dd_r, r1b_r;

  fpci_mul u_gf (.clk(clk), .en(en), .a(s4_r.sf), .b(s4_r.g), .prod(gf));
  fpci_mul u_gn (.clk(clk), .en(en), .a(s4_r.sn), .b(s4_r.g), .prod(gn));
  fpci_mul u_sp (.clk(clk), .en(en), .a(s4_r.sn), .b(s4_r.p), .prod(sp));
  fpci_mul u_t2 (.clk(clk), .en(en), .a(t2_r), .b(a4_r[0].g), .prod(m_t2));

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r    <= s4_nxt;
      a4_r[0] <= s4_r;
      for (int j = 1; j < 7; j++) begin
        a4_r[j] <= a4_r[j-1];
      end
      t2_r  <= fpci_pkg::sat_add(s4_r.sn, s4_r.sn);
      // products land here
      r1_r  <= fpci_pkg::sat_add(a4_r[4].fn, sp);
      e1_r  <= fpci_pkg::sat_sub((a4_r[4].dff <<< 1) + a4_r[4].dff, gf);
      e2_r  <= fpci_pkg::sat_add(gf, gn);
      cc_r  <= fpci_pkg::sat_sub(e1_r, m_t2);
      dd_r  <= fpci_pkg::sat_sub(e2_r, a4_r[5].dff <<< 1);
      r1b_r <= r1_r;
    end
  end

  // ---------------- polynomial terms in the offset fraction ----------------
  side4_t            s120;
  fpci_pkg::word_t   pg_dl_r [10];
  fpci_pkg::word_t   r1_dl_r [10];
  fpci_pkg::word_t   r2_dl_r [4];
  fpci_pkg::status_t st_dl_r [15];
  fpci_pkg::word_t   c1, c2, d1, d2, d3;
  fpci_pkg::word_t   r2_r, r3;
  fpci_pkg::out_item_t out_r, out_nxt;

  assign s120 = a4_r[6];

  fpci_mul u_c1 (.clk(clk), .en(en), .a(cc_r), .b(s120.pg),    .prod(c1));
  fpci_mul u_c2 (.clk(clk), .en(en), .a(c1),   .b(pg_dl_r[4]), .prod(c2));
  fpci_mul u_d1 (.clk(clk), .en(en), .a(dd_r), .b(s120.pg),    .prod(d1));
  fpci_mul u_d2 (.clk(clk), .en(en), .a(d1),   .b(pg_dl_r[4]), .prod(d2));
  fpci_mul u_d3 (.clk(clk), .en(en), .a(d2),   .b(pg_dl_r[9]), .prod(d3));

  // final sum, 32-bit clamp, zero on error
  always_comb begin
    r3 = fpci_pkg::sat_add(r2_dl_r[3], d3);
    if (st_dl_r[14] != fpci_pkg::STATUS_OK) begin
      out_nxt.interpolated = '0;
    end else if (r3 > fpci_pkg::OUT_MAX) begin
      out_nxt.interpolated = fpci_pkg::OUT_MAX[31:0];
    end else if (r3 < fpci_pkg::OUT_MIN) begin
      out_nxt.interpolated = fpci_pkg::OUT_MIN[31:0];
    end else begin
      out_nxt.interpolated = r3[31:0];
    end
    out_nxt.status = st_dl_r[14];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pg_dl_r[0] <= s120.pg;
      r1_dl_r[0] <= r1b_r;
      for (int j = 1; j < 10; j++) begin
        pg_dl_r[j] <= pg_dl_r[j-1];
        r1_dl_r[j] <= r1_dl_r[j-1];
      end
      st_dl_r[0] <= s120.status;
      for (int j = 1; j < 15; j++) begin
        st_dl_r[j] <= st_dl_r[j-1];
      end
      r2_r       <= fpci_pkg::sat_add(r1_dl_r[9], c2);
      r2_dl_r[0] <= r2_r;
      for (int j = 1; j < 4; j++) begin
        r2_dl_r[j] <= r2_dl_r[j-1];
      end
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// ===== hw/rtl/fpci_mul.sv =====
// ---------------------------------------------------------------------------
// fpci_mul
// Pipelined saturating Q31.16 multiply: |a|*|b| >> 16, sign applied,
// clamped to +-(2^47-1). Five register stages, 23/24-bit half products.
// ---------------------------------------------------------------------------
module fpci_mul (
  input  logic            clk,
  input  logic            en,
  input  fpci_pkg::word_t a,
  input  fpci_pkg::word_t b,
  output fpci_pkg::word_t prod
);

  // stage 1: magnitudes
  fpci_pkg::mag_t ua_r, ub_r;
  logic           neg1_r;
  // stage 2: partial products
  logic [45:0]    hh_r;
  logic [46:0]    hl_r, lh_r;
  logic [47:0]    ll_r;
  logic           neg2_r;
  // stage 3: middle sum
  logic [45:0]    hh3_r;
  logic [47:0]    ll3_r, mid_r;
  logic           neg3_r;
  // stage 4: full product
  logic [93:0]    full_r;
  logic           neg4_r;
  // stage 5: result
  fpci_pkg::word_t prod_r;
  fpci_pkg::word_t prod_nxt;
  fpci_pkg::mag_t  res_mag;

  // saturate and sign the product
  always_comb begin
    res_mag  = (|full_r[93:63]) ? fpci_pkg::WMAX[46:0] : full_r[62:16];
    prod_nxt = neg4_r ? -fpci_pkg::word_t'({1'b0, res_mag})
                      : fpci_pkg::word_t'({1'b0, res_mag});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua_r   <= fpci_pkg::mag_of(a);
      ub_r   <= fpci_pkg::mag_of(b);
      neg1_r <= a[47] ^ b[47];

      hh_r   <= ua_r[46:24] * ub_r[46:24];
      hl_r   <= ua_r[46:24] * ub_r[23:0];
      lh_r   <= ua_r[23:0] * ub_r[46:24];
      ll_r   <= ua_r[23:0] * ub_r[23:0];
      neg2_r <= neg1_r;

      hh3_r  <= hh_r;
      ll3_r  <= ll_r;
      mid_r  <= 48'(hl_r) + 48'(lh_r);
      neg3_r <= neg2_r;

      full_r <= {hh3_r, ll3_r} + {22'b0, mid_r, 24'b0};
      neg4_r <= neg3_r;

      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

// ===== hw/rtl/fpci_div.sv =====
// ---------------------------------------------------------------------------
// fpci_div
// Pipelined saturating Q31.16 divide: (|n| << 16) / |d|, sign applied,
// clamped to +-(2^47-1); flags a zero divisor. Restoring, one quotient bit
// per iteration stage, 50 register stages in all.
// ---------------------------------------------------------------------------
module fpci_div (
  input  logic            clk,
  input  logic            en,
  input  fpci_pkg::word_t num,
  input  fpci_pkg::word_t den,
  output fpci_pkg::word_t quo,
  output logic            div_zero
);

  typedef struct packed {
    fpci_pkg::mag_t rem;
    fpci_pkg::mag_t low;
    fpci_pkg::mag_t q;
    fpci_pkg::mag_t d;
    logic           neg;
    logic           sat;
    logic           zero;
  } div_stage_t;

  fpci_pkg::mag_t  ua_r, ub_r;
  logic            neg_r;
  div_stage_t      st_r   [48];
  div_stage_t      st_nxt [48];
  fpci_pkg::word_t quo_r, quo_nxt;
  logic            zero_r;
  fpci_pkg::mag_t  res_mag;

  // setup stage and one quotient bit per iteration stage
  always_comb begin
    logic [47:0] trial;
    logic [47:0] diff;
    logic        ge;
    st_nxt[0].rem  = {31'b0, ua_r[46:31]};
    st_nxt[0].low  = {ua_r[30:0], 16'b0};
    st_nxt[0].q    = '0;
    st_nxt[0].d    = ub_r;
    st_nxt[0].neg  = neg_r;
    st_nxt[0].sat  = (ub_r[46:16] == '0) && (ua_r >= {ub_r[15:0], 31'b0});
    st_nxt[0].zero = (ub_r == '0);
    for (int i = 1; i < 48; i++) begin
      trial = {st_r[i-1].rem, st_r[i-1].low[46]};
      diff  = trial - {1'b0, st_r[i-1].d};
      ge    = (trial >= {1'b0, st_r[i-1].d});
      st_nxt[i]     = st_r[i-1];
      st_nxt[i].rem = ge ? diff[46:0] : trial[46:0];
      st_nxt[i].low = {st_r[i-1].low[45:0], 1'b0};
      st_nxt[i].q   = {st_r[i-1].q[45:0], ge};
    end
  end

  // final saturation and sign
  always_comb begin
    if (st_r[47].zero) begin
      res_mag = '0;
    end else if (st_r[47].sat) begin
      res_mag = fpci_pkg::WMAX[46:0];
    end else begin
      res_mag = st_r[47].q;
    end
    quo_nxt = st_r[47].neg ? -fpci_pkg::word_t'({1'b0, res_mag})
                           : fpci_pkg::word_t'({1'b0, res_mag});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua_r  <= fpci_pkg::mag_of(num);
      ub_r  <= fpci_pkg::mag_of(den);
      neg_r <= num[47] ^ den[47];
      for (int i = 0; i < 48; i++) begin
        st_r[i] <= st_nxt[i];
      end
      quo_r  <= quo_nxt;
      zero_r <= st_r[47].zero;
    end
  end

  assign quo      = quo_r;
  assign div_zero = zero_r;

endmodule

// ===== test/four_point_cubic_interpolator_tb.sv =====
// ---------------------------------------------------------------------------
// four_point_cubic_interpolator_tb
// Drives four-point interpolation items through the pipelined interpolator
// with random idling on both channels, then at full rate. A behavioral
// model of the Q16.16 Hermite arithmetic predicts each result, and the
// results are compared in order.
// ---------------------------------------------------------------------------
module four_point_cubic_interpolator_tb;

  typedef longint signed w64_t;
  typedef longint unsigned u64_t;

  localparam w64_t WLIM  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam w64_t UNITQ = 64'sh0000_0000_0001_0000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  fpci_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  fpci_pkg::out_item_t out_data;

  fpci_pkg::out_item_t expected_q[$];
  int        error_count;
  int        item_count;
  int        result_count;
  bit        quiet;       // no idling on either side
  bit        div_zero;    // set when a division meets a zero divisor
  int        rx_hold;

  four_point_cubic_interpolator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---- Q31.16 saturating arithmetic -------------------------------------
  function automatic w64_t clampw(w64_t v);
    if (v > WLIM) return WLIM;
    if (v < -WLIM) return -WLIM;
    return v;
  endfunction

  function automatic u64_t magn(w64_t v);
    return (v < 0) ? u64_t'(-v) : u64_t'(v);
  endfunction

  function automatic w64_t qmul(w64_t a, w64_t b);
    bit   neg;
    u64_t ua, ub, bh, bl, r;
    neg = (a < 0) != (b < 0);
    ua = magn(a);
    ub = magn(b);
    bh = ub >> 16;
    bl = ub & 64'hFFFF;
    if (bh != 0 && ua > u64_t'(WLIM) / bh) begin
      r = u64_t'(WLIM);
    end else begin
      r = ua * bh + ((ua * bl) >> 16);
      if (r > u64_t'(WLIM)) r = u64_t'(WLIM);
    end
    return neg ? -w64_t'(r) : w64_t'(r);
  endfunction

  function automatic w64_t qdiv(w64_t a, w64_t b);
    bit   neg;
    u64_t ua, ub, q;
    neg = (a < 0) != (b < 0);
    ua = magn(a);
    ub = magn(b);
    if (ub == 0) begin
      div_zero = 1'b1;
      return 0;
    end
    q = (ua << 16) / ub;
    if (q > u64_t'(WLIM)) q = u64_t'(WLIM);
    return neg ? -w64_t'(q) : w64_t'(q);
  endfunction

  // ---- Expected interpolation result --------------------------------------
  function automatic fpci_pkg::out_item_t interp_expect(fpci_pkg::in_item_t x);
    fpci_pkg::out_item_t o;
    w64_t fb, fn, ff, fa, pb, pn, pf, pa, qp;
    w64_t g, p, dff, sf, sn, k, hc, pg, cc, dd, gf, gn, r;
    fb = x.sample_before;  fn = x.sample_near;
    ff = x.sample_far;     fa = x.sample_after;
    pb = x.pos_before;     pn = x.pos_near;
    pf = x.pos_far;        pa = x.pos_after;
    qp = x.query_pos;
    g = pf - pn;
    p = qp - pn;
    dff = ff - fn;
    o.interpolated = '0;
    if (p < 0 || p > g) begin
      o.status = fpci_pkg::STATUS_RANGE;
      return o;
    end
    div_zero = 1'b0;
    // far end slope, chord fallback on a flat outer sample
    if (fa == ff) begin
      sf = qdiv(dff, g);
    end else begin
      k = qdiv(g, pa - pf);
      sf = qdiv(clampw((fn - ff) - qmul(qmul(fa - ff, k), k)),
                qmul(-g, clampw(UNITQ + k)));
    end
    // near end slope
    if (fb == fn) begin
      sn = qdiv(dff, g);
    end else begin
      hc = pb - pn;
      k = qdiv(hc, g);
      sn = qdiv(clampw((fb - fn) - qmul(qmul(dff, k), k)),
                qmul(hc, clampw(UNITQ - k)));
    end
    pg = qdiv(p, g);
    if (div_zero) begin
      o.status = fpci_pkg::STATUS_SPACING;
      return o;
    end
    gf = qmul(sf, g);
    gn = qmul(sn, g);
    cc = clampw(clampw(3 * dff - gf) - qmul(clampw(sn + sn), g));
    dd = clampw(clampw(gf + gn) - 2 * dff);
    r = clampw(fn + qmul(sn, p));
    r = clampw(r + qmul(qmul(cc, pg), pg));
    r = clampw(r + qmul(qmul(qmul(dd, pg), pg), pg));
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    o.interpolated = r[31:0];
    o.status = fpci_pkg::STATUS_OK;
    return o;
  endfunction

  function automatic fpci_pkg::in_item_t make_item(w64_t fb, w64_t fn, w64_t ff,
                                                   w64_t fa, w64_t pb, w64_t pn,
                                                   w64_t pf, w64_t pa, w64_t qp);
    fpci_pkg::in_item_t x;
    x.sample_before = fb[31:0];  x.sample_near = fn[31:0];
    x.sample_far    = ff[31:0];  x.sample_after = fa[31:0];
    x.pos_before    = pb[31:0];  x.pos_near    = pn[31:0];
    x.pos_far       = pf[31:0];  x.pos_after   = pa[31:0];
    x.query_pos     = qp[31:0];
    return x;
  endfunction

  // Random signed value with a random magnitude scale
  function automatic w64_t rand_scaled();
    w64_t v;
    v = w64_t'($urandom >> $urandom_range(1, 31));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // Ordered positions, query inside the span, random content
  function automatic fpci_pkg::in_item_t rand_well_formed();
    w64_t fb, fn, ff, fa, pn, h1, h2, h3, qp;
    fn = rand_scaled();
    ff = rand_scaled();
    fb = ($urandom_range(0, 5) == 0) ? fn : rand_scaled();
    fa = ($urandom_range(0, 5) == 0) ? ff : rand_scaled();
    pn = w64_t'($urandom_range(0, 32'h3FFF_FFFF)) - 64'sh2000_0000;
    h1 = $urandom_range(1, 1 << $urandom_range(2, 24));
    h2 = $urandom_range(1, 1 << $urandom_range(2, 24));
    h3 = $urandom_range(1, 1 << $urandom_range(2, 24));
    case ($urandom_range(0, 9))
      0:       qp = pn;
      1:       qp = pn + h2;
      default: qp = pn + $urandom_range(0, 32'(h2));
    endcase
    return make_item(fb, fn, ff, fa, pn - h1, pn, pn + h2, pn + h2 + h3, qp);
  endfunction

  // Either a fully random item or a broken sequence
  function automatic fpci_pkg::in_item_t rand_noise();
    fpci_pkg::in_item_t x;
    x = rand_well_formed();
    case ($urandom_range(0, 4))
      0: x = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom};
      1: x.query_pos = x.pos_near - $urandom_range(1, 1000);
      2: x.query_pos = x.pos_far + $urandom_range(1, 1000);
      3: x.pos_after = x.pos_far;
      default: x.pos_before = x.pos_near;
    endcase
    return x;
  endfunction

  // ---- One input transfer -------------------------------------------------
  task automatic send_item(fpci_pkg::in_item_t x);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(interp_expect(x));
    item_count++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // ---- Result checker -------------------------------------------------------
  always @(posedge clk) begin
    fpci_pkg::out_item_t exp_item;
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h/%0d", $time, out_data.interpolated,
                 out_data.status);
        error_count++;
      end else begin
        exp_item = expected_q.pop_front();
        if (out_data.interpolated !== exp_item.interpolated) begin
          $display("%0t: interpolated expected %h actual %h", $time,
                   exp_item.interpolated, out_data.interpolated);
          error_count++;
        end
        if (out_data.status !== exp_item.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_item.status, out_data.status);
          error_count++;
        end
      end
    end
  end

  // ---- Receiver backpressure in bursts ---------------------------------------
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (rx_hold > 0) begin
      rx_hold--;
      rdy = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rx_hold = $urandom_range(0, 10);
      rdy = 1'b0;
    end
    out_ready = rdy;
  end

  // ---- Tests ------------------------------------------------------------------
  task automatic test_directed();
    w64_t mx, mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    send_item(make_item(mx, mx, mx, mx, mx, mx, mx, mx, mx));
    send_item(make_item(mn, mn, mn, mn, mn, mn, mn, mn, mn));
    send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
    // linear data, unit spacing
    send_item(make_item(0, 65536, 131072, 196608, 0, 65536, 131072, 196608, 98304));
    // query exactly at each inner end
    send_item(make_item(5, 70000, -3000, 8, -65536, 0, 65536, 131072, 0));
    send_item(make_item(5, 70000, -3000, 8, -65536, 0, 65536, 131072, 65536));
    // query outside the span on either side, reversed span
    send_item(make_item(1, 2, 3, 4, 0, 100, 200, 300, 99));
    send_item(make_item(1, 2, 3, 4, 0, 100, 200, 300, 201));
    send_item(make_item(1, 2, 3, 4, 300, 200, 100, 0, 150));
    // zero span with query on it
    send_item(make_item(1, 2, 3, 4, 0, 100, 100, 300, 100));
    // coincident outer and inner positions
    send_item(make_item(1, 2, 3, 4, 0, 100, 200, 200, 150));
    send_item(make_item(1, 2, 3, 4, 100, 100, 200, 300, 150));
    // outer position coinciding with the opposite inner one
    send_item(make_item(1, 2, 3, 4, 200, 100, 200, 300, 150));
    send_item(make_item(1, 2, 3, 4, 0, 100, 200, 100, 150));
    // flat outer samples use the chord slope
    send_item(make_item(7, 7, 900000, 900000, -65536, 0, 65536, 131072, 30000));
    send_item(make_item(7, 7, 900000, 12, -65536, 0, 65536, 131072, 30000));
    // tiny spacing, huge samples: saturation
    send_item(make_item(mn, mx, mn, mx, 0, 1, 2, 3, 1));
    send_item(make_item(mx, mn, mx, mn, mn, mn + 1, mx - 1, mx, 0));
    send_item(make_item(mn, mx, mn, mx, mn, -1, 1, mx, 0));
    // wide span, rounding toward a zero divisor
    send_item(make_item(1, -1, 1, -1, mn, mn + 1, mx - 1, mx, 1));
    release_input();
  endtask

  task automatic test_random(int count);
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) send_item(rand_noise());
      else send_item(rand_well_formed());
    end
    release_input();
  endtask

  // Let the pipeline run dry before continuing
  task automatic test_drain_pause();
    test_random(20);
    wait (expected_q.size() == 0);
    test_random(20);
  endtask

  task automatic test_full_rate(int count);
    quiet = 1'b1;
    test_random(count);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    error_count = 0;
    item_count = 0;
    result_count = 0;
    quiet = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(440);
    test_drain_pause();
    test_full_rate(100);

    wait (expected_q.size() == 0);
    repeat (fpci_pkg::PIPE_LEN + 20) @(posedge clk);
    if (expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_q.size());
      error_count++;
    end
    $display("Ran %0d items (directed extremes, spacing and range cases, random)", item_count);
    $display("Checked %0d results with random idling, then at full rate", result_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
